[src/efi_pkg.sv]
// Shared types and constants for the escape-time fractal iterator.
// Used by efi_csr, efi_ctrl, efi_dp and the top level; no dependencies.
package efi_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS       = 28;
   localparam int LIMIT_WIDTH     = 32;
   localparam int ITER_WIDTH      = 16;
   localparam int EXP_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   // Defaults for the top-level parameters
   localparam int COORD_WIDTH_DEFAULT  = 32;
   localparam int MAX_EXPONENT_DEFAULT = 9;

   // Register reset values
   localparam logic [ITER_WIDTH-1:0]  ITER_LIMIT_RESET   = 16'd20;
   localparam logic [EXP_WIDTH-1:0]   EXPONENT_RESET     = 4'd2;
   localparam logic [LIMIT_WIDTH-1:0] ESCAPE_LIMIT_RESET = 32'd697932186; // 2.6 in Q4.28

   // Register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ITER_LIMIT   = 3'd0,
      REG_EXPONENT     = 3'd1,
      REG_BURN_MODE    = 3'd2,
      REG_JULIA_MODE   = 3'd3,
      REG_JULIA_RE     = 3'd4,
      REG_JULIA_IM     = 3'd5,
      REG_ESCAPE_LIMIT = 3'd6
   } csr_index_type;

   // Fixed-width configuration fields
   typedef struct packed {
      logic [ITER_WIDTH-1:0]  iter_limit;
      logic [EXP_WIDTH-1:0]   exponent;
      logic                   burn_mode;
      logic                   julia_mode;
      logic [LIMIT_WIDTH-1:0] escape_limit;
   } cfg_type;

   // Datapath commands
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,     // start a point: set z, c, clear count and magnitude
      DP_PREP,     // z and base take |z| parts when burning
      DP_MUL,      // four cross products into the product registers
      DP_ACC,      // combine products into the next power of z
      DP_ADDC,     // z += c
      DP_SQR,      // squares of z parts into the product registers
      DP_MAG       // magnitude sum, count one iteration
   } dp_op_type;

   // Datapath status back to the controller
   typedef struct packed {
      logic below_cap;    // iteration count below iter_limit
      logic below_limit;  // |z|^2 below escape_limit
   } dp_status_type;

endpackage

[src/escape_time_fractal_iterator.sv]
// Escape-time iterator: one point in, one iteration count out, one point at a time.
// Each iteration runs a prep step, a multiply and accumulate pair per power step
// beyond the first, the add of c, the squares and the magnitude. The block is
// ready for the next point as soon as a result is registered. The four shared
// multipliers serve each power step and the magnitude squares in turn. Synchronous
// active-high reset clears the controller and loads the register reset values.
module escape_time_fractal_iterator #(
   parameter int COORD_WIDTH  = efi_pkg::COORD_WIDTH_DEFAULT,
   parameter int MAX_EXPONENT = efi_pkg::MAX_EXPONENT_DEFAULT,
   parameter int CSR_DATA_WIDTH = (COORD_WIDTH > efi_pkg::LIMIT_WIDTH) ?
                                  COORD_WIDTH : efi_pkg::LIMIT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_point_re,
   input  logic signed [COORD_WIDTH-1:0]       req_point_im,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [efi_pkg::ITER_WIDTH-1:0]      rsp_iter_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [efi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]           csr_data
);

   efi_pkg::cfg_type              cfg;
   logic signed [COORD_WIDTH-1:0] julia_re;
   logic signed [COORD_WIDTH-1:0] julia_im;
   efi_pkg::dp_op_type            op;
   efi_pkg::dp_status_type        dp_stat;
   logic                          publish;

   efi_csr #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (CSR_DATA_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .julia_re  (julia_re),
      .julia_im  (julia_im)
   );

   efi_ctrl #(
      .MAX_EXPONENT (MAX_EXPONENT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cfg       (cfg),
      .status    (dp_stat),
      .op        (op),
      .publish   (publish)
   );

   efi_dp #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .op         (op),
      .publish    (publish),
      .cfg        (cfg),
      .julia_re   (julia_re),
      .julia_im   (julia_im),
      .point_re   (req_point_re),
      .point_im   (req_point_im),
      .status     (dp_stat),
      .iter_count (rsp_iter_count)
   );

`ifndef SYNTH
   // A count never exceeds the cap
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iter_count <= cfg.iter_limit))
      else $error("iteration count above cap");

   // An accepted point leaves the block busy in the cycle after the accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again right after accept");

   // A result appears only once the loop has stopped
   a_result_on_stop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !($past(dp_stat.below_cap) && $past(dp_stat.below_limit)))
      else $error("result raised while iterating");
`endif

endmodule

[src/efi_csr.sv]
// Configuration register file for the escape-time fractal iterator.
// Depends on efi_pkg for the register map, reset values and cfg_type.
module efi_csr #(
   parameter int COORD_WIDTH = efi_pkg::COORD_WIDTH_DEFAULT,
   parameter int DATA_WIDTH  = efi_pkg::LIMIT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [efi_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [DATA_WIDTH-1:0]                 csr_data,
   output efi_pkg::cfg_type                      cfg,
   output logic signed [COORD_WIDTH-1:0]         julia_re,
   output logic signed [COORD_WIDTH-1:0]         julia_im
);

   efi_pkg::cfg_type               cfg_ff;
   logic signed [COORD_WIDTH-1:0]  julia_re_ff;
   logic signed [COORD_WIDTH-1:0]  julia_im_ff;

   // Always ready: every write is accepted when offered
   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.iter_limit   <= efi_pkg::ITER_LIMIT_RESET;
         cfg_ff.exponent     <= efi_pkg::EXPONENT_RESET;
         cfg_ff.burn_mode    <= 1'b0;
         cfg_ff.julia_mode   <= 1'b0;
         cfg_ff.escape_limit <= efi_pkg::ESCAPE_LIMIT_RESET;
         julia_re_ff         <= '0;
         julia_im_ff         <= '0;
      end else if (csr_valid) begin
         case (efi_pkg::csr_index_type'(csr_index))
            efi_pkg::REG_ITER_LIMIT: begin
               cfg_ff.iter_limit <= csr_data[efi_pkg::ITER_WIDTH-1:0];
            end
            efi_pkg::REG_EXPONENT: begin
               cfg_ff.exponent <= csr_data[efi_pkg::EXP_WIDTH-1:0];
            end
            efi_pkg::REG_BURN_MODE: begin
               cfg_ff.burn_mode <= csr_data[0];
            end
            efi_pkg::REG_JULIA_MODE: begin
               cfg_ff.julia_mode <= csr_data[0];
            end
            efi_pkg::REG_JULIA_RE: begin
               julia_re_ff <= csr_data[COORD_WIDTH-1:0];
            end
            efi_pkg::REG_JULIA_IM: begin
               julia_im_ff <= csr_data[COORD_WIDTH-1:0];
            end
            efi_pkg::REG_ESCAPE_LIMIT: begin
               cfg_ff.escape_limit <= csr_data[efi_pkg::LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg      = cfg_ff;
   assign julia_re = julia_re_ff;
   assign julia_im = julia_im_ff;

endmodule

[src/efi_dp.sv]
// Datapath of the escape-time fractal iterator: z, c, the shared products,
// magnitude, iteration count and result register. Depends on efi_pkg.
module efi_dp #(
   parameter int COORD_WIDTH = efi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  efi_pkg::dp_op_type                  op,
   input  logic                                publish,
   input  efi_pkg::cfg_type                    cfg,
   input  logic signed [COORD_WIDTH-1:0]       julia_re,
   input  logic signed [COORD_WIDTH-1:0]       julia_im,
   input  logic signed [COORD_WIDTH-1:0]       point_re,
   input  logic signed [COORD_WIDTH-1:0]       point_im,
   output efi_pkg::dp_status_type              status,
   output logic [efi_pkg::ITER_WIDTH-1:0]      iter_count
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W;    // full product
   localparam int SW = PW + 1;   // sum of two shifted products
   localparam int LW = efi_pkg::LIMIT_WIDTH;

   localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0]            z_re_ff, z_im_ff;
   logic signed [W-1:0]            b_re_ff, b_im_ff;
   logic signed [W-1:0]            c_re_ff, c_im_ff;
   logic signed [PW-1:0]           p0_ff, p1_ff, p2_ff, p3_ff;
   logic [LW-1:0]                  mag_ff;
   logic [efi_pkg::ITER_WIDTH-1:0] iter_ff;
   logic [efi_pkg::ITER_WIDTH-1:0] rsp_count_ff;

   logic signed [W-1:0]            mul_b0, mul_b1;
   logic signed [PW-1:0]           p0_in, p1_in, p2_in, p3_in;
   logic signed [SW-1:0]           q0, q1, q2, q3;
   logic signed [SW-1:0]           re_sum, im_sum, mag_sum;
   logic signed [SW-1:0]           addc_re, addc_im;
   logic [LW-1:0]                  mag_in;
   logic signed [W-1:0]            f_re, f_im;

   // Clamp a wide signed sum to the coordinate range
   function automatic logic signed [W-1:0] sat_coord(input logic signed [SW-1:0] s);
      logic [SW-W:0] top;
      top = s[SW-1:W-1];
      if ((&top) || !(|top)) begin
         return s[W-1:0];
      end else if (s[SW-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

   // Absolute value; the most negative code goes to the largest positive
   function automatic logic signed [W-1:0] abs_coord(input logic signed [W-1:0] v);
      if (v == COORD_MIN) begin
         return COORD_MAX;
      end else if (v[W-1]) begin
         return -v;
      end else begin
         return v;
      end
   endfunction

   // Shared multipliers: cross products, or squares for the magnitude
   assign mul_b0 = (op == efi_pkg::DP_SQR) ? z_re_ff : b_re_ff;
   assign mul_b1 = (op == efi_pkg::DP_SQR) ? z_im_ff : b_im_ff;
   assign p0_in  = z_re_ff * mul_b0;
   assign p1_in  = z_im_ff * mul_b1;
   assign p2_in  = b_re_ff * z_im_ff;
   assign p3_in  = b_im_ff * z_re_ff;

   // Products back to Q4.28, rounding toward minus infinity
   assign q0 = SW'(p0_ff >>> efi_pkg::FRAC_BITS);
   assign q1 = SW'(p1_ff >>> efi_pkg::FRAC_BITS);
   assign q2 = SW'(p2_ff >>> efi_pkg::FRAC_BITS);
   assign q3 = SW'(p3_ff >>> efi_pkg::FRAC_BITS);

   assign re_sum  = q0 - q1;
   assign im_sum  = q2 + q3;
   assign mag_sum = q0 + q1;

   // Squares are non-negative; clamp the sum to the unsigned limit width
   assign mag_in = (|mag_sum[SW-1:LW]) ? {LW{1'b1}} : mag_sum[LW-1:0];

   assign addc_re = SW'(z_re_ff) + SW'(c_re_ff);
   assign addc_im = SW'(z_im_ff) + SW'(c_im_ff);

   assign f_re = cfg.burn_mode ? abs_coord(z_re_ff) : z_re_ff;
   assign f_im = cfg.burn_mode ? abs_coord(z_im_ff) : z_im_ff;

   // Datapath registers, one command per cycle
   always_ff @(posedge clock) begin
      case (op)
         efi_pkg::DP_LOAD: begin
            if (cfg.julia_mode) begin
               z_re_ff <= point_re;
               z_im_ff <= point_im;
               c_re_ff <= julia_re;
               c_im_ff <= julia_im;
            end else begin
               z_re_ff <= '0;
               z_im_ff <= '0;
               c_re_ff <= point_re;
               c_im_ff <= point_im;
            end
            mag_ff  <= '0;
            iter_ff <= '0;
         end
         efi_pkg::DP_PREP: begin
            z_re_ff <= f_re;
            z_im_ff <= f_im;
            b_re_ff <= f_re;
            b_im_ff <= f_im;
         end
         efi_pkg::DP_MUL, efi_pkg::DP_SQR: begin
            p0_ff <= p0_in;
            p1_ff <= p1_in;
            p2_ff <= p2_in;
            p3_ff <= p3_in;
         end
         efi_pkg::DP_ACC: begin
            z_re_ff <= sat_coord(re_sum);
            z_im_ff <= sat_coord(im_sum);
         end
         efi_pkg::DP_ADDC: begin
            z_re_ff <= sat_coord(addc_re);
            z_im_ff <= sat_coord(addc_im);
         end
         efi_pkg::DP_MAG: begin
            mag_ff  <= mag_in;
            iter_ff <= iter_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result register, loaded when the controller hands off a count
   always_ff @(posedge clock) begin
      if (publish) begin
         rsp_count_ff <= iter_ff;
      end
   end

   assign status.below_cap   = (iter_ff < cfg.iter_limit);
   assign status.below_limit = (mag_ff < cfg.escape_limit);
   assign iter_count         = rsp_count_ff;

endmodule

[src/efi_ctrl.sv]
// Controller of the escape-time fractal iterator: sequences the datapath
// per iteration and owns both handshakes. Depends on efi_pkg.
module efi_ctrl #(
   parameter int MAX_EXPONENT = efi_pkg::MAX_EXPONENT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  efi_pkg::cfg_type         cfg,
   input  efi_pkg::dp_status_type   status,
   output efi_pkg::dp_op_type       op,
   output logic                     publish
);

   localparam int STEP_W = $clog2(MAX_EXPONENT + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_MUL,
      ST_ACC,
      ST_ADDC,
      ST_SQR,
      ST_MAG
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic [STEP_W-1:0] power;
   logic              go;
   logic              out_free;
   logic              more_steps;

   // Effective power: zero acts as one, large values clamp
   always_comb begin
      if (cfg.exponent == '0) begin
         power = STEP_W'(1);
      end else if (int'(cfg.exponent) > MAX_EXPONENT) begin
         power = STEP_W'(MAX_EXPONENT);
      end else begin
         power = STEP_W'(cfg.exponent);
      end
   end

   assign go         = status.below_cap && status.below_limit;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign more_steps = ({1'b0, step_ff} + 1'b1) < {1'b0, power};
   assign publish    = (state_ff == ST_TEST) && !go && out_free;

   // Command decode
   always_comb begin
      case (state_ff)
         ST_IDLE: op = req_valid ? efi_pkg::DP_LOAD : efi_pkg::DP_NOP;
         ST_TEST: op = go ? efi_pkg::DP_PREP : efi_pkg::DP_NOP;
         ST_MUL:  op = efi_pkg::DP_MUL;
         ST_ACC:  op = efi_pkg::DP_ACC;
         ST_ADDC: op = efi_pkg::DP_ADDC;
         ST_SQR:  op = efi_pkg::DP_SQR;
         ST_MAG:  op = efi_pkg::DP_MAG;
         default: op = efi_pkg::DP_NOP;
      endcase
   end

   // State, power step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // valid drops on accept unless a new count goes out the same cycle
         if (rsp_valid_ff && rsp_ready && !publish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               if (go) begin
                  step_ff  <= STEP_W'(1);
                  state_ff <= (power > STEP_W'(1)) ? ST_MUL : ST_ADDC;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (more_steps) begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_ADDC;
               end
            end
            ST_ADDC: begin
               state_ff <= ST_SQR;
            end
            ST_SQR: begin
               state_ff <= ST_MAG;
            end
            ST_MAG: begin
               state_ff <= ST_TEST;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
